>>> rtl/cpas_pkg.sv
// Shared types, codes and resource tables of the cache pipe admission scoreboard.
package cpas_pkg;

	localparam int SET_W = 12;
	localparam int BANK_W = 3;
	localparam int TAG_W = 8;
	localparam int SRC_W = 3;
	localparam int RES_W = 5;
	localparam int GSTAGE_W = 3;
	localparam int DWS_W = 4;
	localparam int CFG_IDX_W = 1;

	localparam int GRANT_HI = 4;
	localparam int GRANT_LO = 2;

	localparam logic [RES_W-1:0] RES_DIR_RD  = 5'b00001;
	localparam logic [RES_W-1:0] RES_DIR_WR  = 5'b00010;
	localparam logic [RES_W-1:0] RES_DATA_RD = 5'b00100;
	localparam logic [RES_W-1:0] RES_DATA_WR = 5'b01000;
	localparam logic [RES_W-1:0] RES_GRANT   = 5'b10000;

	localparam logic [SRC_W-1:0] SRC_L1_ACQ   = 3'd0;
	localparam logic [SRC_W-1:0] SRC_L1_WB    = 3'd1;
	localparam logic [SRC_W-1:0] SRC_SNOOP    = 3'd2;
	localparam logic [SRC_W-1:0] SRC_GRANT    = 3'd3;
	localparam logic [SRC_W-1:0] SRC_RELEASE  = 3'd4;
	localparam logic [SRC_W-1:0] SRC_PREFETCH = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_DIR_WRITE_STAGE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_READ_BYPASS = 1'b1;

	localparam logic [DWS_W-1:0] DWS_RESET = 4'd3;

	typedef struct packed {
		logic              valid;
		logic [SRC_W-1:0]  source;
		logic [RES_W-1:0]  res;
		logic [SET_W-1:0]  set_idx;
		logic [BANK_W-1:0] dir_bank;
		logic [BANK_W-1:0] data_bank;
		logic [TAG_W-1:0]  tag;
	} stage_t;

	typedef struct packed {
		logic [SRC_W-1:0]  source;
		logic              hit;
		logic              is_upgrade;
		logic [SET_W-1:0]  set_idx;
		logic [BANK_W-1:0] dir_bank;
		logic [BANK_W-1:0] data_bank;
		logic [TAG_W-1:0]  tag;
	} req_t;

	typedef struct packed {
		logic             accept;
		logic             set_conflict;
		logic             data_stall;
		logic             dir_stall;
		logic [RES_W-1:0] res;
	} check_t;

	typedef struct packed {
		logic                valid;
		logic [TAG_W-1:0]    tag;
		logic [GSTAGE_W-1:0] stage_num;
	} grant_t;

	typedef struct packed {
		logic                accepted;
		logic                set_conflict;
		logic                data_bank_stall;
		logic                dir_bank_stall;
		logic                grant_valid;
		logic [TAG_W-1:0]    grant_tag;
		logic [GSTAGE_W-1:0] grant_stage;
		logic                busy_res;
	} result_t;

	// Resources a request needs, from its source and its hit and upgrade flags.
	function automatic logic [RES_W-1:0] full_res(input logic [SRC_W-1:0] src,
			input logic hit, input logic upg);
		logic [RES_W-1:0] r;
		case (src)
			SRC_L1_ACQ: begin
				r = RES_DIR_RD;
				if (hit) begin
					r = r | RES_DIR_WR;
					if (!upg)
						r = r | RES_DATA_RD;
				end
			end
			SRC_L1_WB:    r = RES_DIR_RD | RES_DIR_WR | RES_DATA_WR | RES_GRANT;
			SRC_SNOOP:    r = hit ? (RES_DIR_RD | RES_DIR_WR | RES_DATA_RD) : RES_DIR_RD;
			SRC_GRANT:    r = RES_DIR_RD | RES_DATA_RD | RES_GRANT;
			SRC_RELEASE:  r = RES_DATA_WR;
			SRC_PREFETCH: r = RES_DIR_RD;
			default:      r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/cache_pipe_admission_scoreboard_top.sv
// Top level of the cache pipe admission scoreboard: input stage, checks, stages, result register.
//
//  channel   dir  signals                          beat contents
//  s_axis    in   s_tvalid s_tready s_tdata s_tuser one tick or one request
//  m_axis    out  m_tvalid m_tready m_tdata        one result per input beat
//  cfg       in   cfg_wr_en cfg_addr cfg_data       register write, no handshake
//
// An input beat is registered, then checked and applied to the stages in the
// following cycle, its result landing in the output register; one beat per
// cycle is sustained while the output is not stalled, set by the single stage update.
// Reset empties every stage and loads the register defaults; no clearing pass.
// A stalled output holds its result while one further beat waits in the input
// register; the input side is then held off until the output drains.
module cache_pipe_admission_scoreboard_top #(
	parameter int PIPE_DEPTH = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// source[2:0], hit[3], is_upgrade[4], set_index[16:5], dir_bank[19:17],
	// data_bank[22:20], task_tag[30:23], zero[31]
	input  logic [31:0]                        s_tdata,
	// mode[0]
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// accepted[0], set_conflict[1], data_bank_stall[2], dir_bank_stall[3],
	// grant_valid[4], grant_tag[12:5], grant_stage[15:13], busy_res[16], zero[23:17]
	output logic [23:0]                        m_tdata,
	input  logic                               cfg_wr_en,
	input  logic [cpas_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [cpas_pkg::DWS_W-1:0]         cfg_data
);
	import cpas_pkg::*;

	logic                    valid_s1;
	logic                    mode_s1;
	req_t                    req_s1;
	logic                    out_valid_q;
	result_t                 res_q;
	logic [DWS_W-1:0]        dws_q;
	logic                    bypass_q;
	logic                    fire;
	logic                    tick;
	stage_t [PIPE_DEPTH-1:0] stages;
	check_t                  chk;
	grant_t                  grant;
	grant_t                  grant_eff;
	stage_t                  new_stage;
	logic                    busy_next;
	result_t                 res_d;

	assign fire = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;
	assign tick = !mode_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1 <= s_tuser;
			req_s1.source <= s_tdata[2:0];
			req_s1.hit <= s_tdata[3];
			req_s1.is_upgrade <= s_tdata[4];
			req_s1.set_idx <= s_tdata[16:5];
			req_s1.dir_bank <= s_tdata[19:17];
			req_s1.data_bank <= s_tdata[22:20];
			req_s1.tag <= s_tdata[30:23];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dws_q <= DWS_RESET;
			bypass_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_DIR_WRITE_STAGE: dws_q <= cfg_data;
				REG_DIR_READ_BYPASS: bypass_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	cpas_check #(
		.PIPE_DEPTH(PIPE_DEPTH)
	) u_check (
		.req(req_s1),
		.stages(stages),
		.dir_write_stage(dws_q),
		.dir_read_bypass(bypass_q),
		.chk(chk),
		.grant(grant)
	);

	always_comb begin
		new_stage.valid = 1'b1;
		new_stage.source = req_s1.source;
		new_stage.res = chk.res;
		new_stage.set_idx = req_s1.set_idx;
		new_stage.dir_bank = req_s1.dir_bank;
		new_stage.data_bank = req_s1.data_bank;
		new_stage.tag = req_s1.tag;
		grant_eff = tick ? grant : '0;
	end

	cpas_stages #(
		.PIPE_DEPTH(PIPE_DEPTH)
	) u_stages (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.tick(tick),
		.insert(chk.accept),
		.grant(grant_eff),
		.new_stage(new_stage),
		.stages(stages),
		.busy_next(busy_next)
	);

	always_comb begin
		res_d.accepted = !tick && chk.accept;
		res_d.set_conflict = !tick && chk.set_conflict;
		res_d.data_bank_stall = !tick && chk.data_stall;
		res_d.dir_bank_stall = !tick && chk.dir_stall;
		res_d.grant_valid = grant_eff.valid;
		res_d.grant_tag = grant_eff.tag;
		res_d.grant_stage = grant_eff.stage_num;
		res_d.busy_res = busy_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			res_q <= res_d;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {7'b0, res_q.busy_res, res_q.grant_stage, res_q.grant_tag,
		res_q.grant_valid, res_q.dir_bank_stall, res_q.data_bank_stall,
		res_q.set_conflict, res_q.accepted};

	a_accept_without_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_q.accepted
		|-> !res_q.set_conflict && !res_q.data_bank_stall && !res_q.dir_bank_stall)
		else $error("request accepted although a stall was flagged");

	a_grant_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_q.grant_valid |-> !res_q.accepted
		&& (res_q.grant_stage == 3'd2 || res_q.grant_stage == 3'd3
		|| res_q.grant_stage == 3'd4))
		else $error("grant reported outside stages two to four or with an accept");

	a_accept_makes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_q.accepted |-> res_q.busy_res)
		else $error("accepted request left the pipeline idle");

endmodule

>>> rtl/cpas_check.sv
// Admission checks of a request and grant selection against the current stages.
module cpas_check #(
	parameter int PIPE_DEPTH = 8
) (
	input  cpas_pkg::req_t                    req,
	input  cpas_pkg::stage_t [PIPE_DEPTH-1:0] stages,
	input  logic [cpas_pkg::DWS_W-1:0]        dir_write_stage,
	input  logic                              dir_read_bypass,
	output cpas_pkg::check_t                  chk,
	output cpas_pkg::grant_t                  grant
);
	import cpas_pkg::*;

	localparam int IDX_W = $clog2(PIPE_DEPTH);

	logic [DWS_W-1:0] d_full;
	logic [IDX_W-1:0] d_idx;
	logic             known_src;
	logic [RES_W-1:0] need;
	logic [RES_W-1:0] need_chk;
	logic             set_blk;
	stage_t           d_stage;

	always_comb begin
		d_full = (dir_write_stage == '0) ? '0 : dir_write_stage - DWS_W'(1);
		if (int'(d_full) > PIPE_DEPTH - 1)
			d_idx = IDX_W'(PIPE_DEPTH - 1);
		else
			d_idx = d_full[IDX_W-1:0];
	end

	assign d_stage = stages[d_idx];
	assign known_src = (req.source <= SRC_PREFETCH);
	assign need = full_res(req.source, req.hit, req.is_upgrade);

	always_comb begin
		set_blk = 1'b0;
		for (int i = 1; i < PIPE_DEPTH; i++) begin
			if (i <= int'(d_idx) && stages[i].valid && stages[i].set_idx == req.set_idx)
				set_blk = 1'b1;
		end
		if (req.source != SRC_L1_ACQ || dir_read_bypass)
			set_blk = 1'b0;
	end

	// With bypass on, an acquire to the set sitting at the directory write stage
	// reads the directory through the bypass path and needs no directory read.
	always_comb begin
		need_chk = need;
		if (dir_read_bypass && req.source == SRC_L1_ACQ && d_stage.set_idx == req.set_idx)
			need_chk = need & ~RES_DIR_RD;
	end

	always_comb begin
		chk.res = need;
		chk.set_conflict = set_blk;
		chk.data_stall = ((need_chk & (RES_DATA_RD | RES_DATA_WR)) != '0)
			&& ((stages[1].res & (RES_DATA_RD | RES_DATA_WR)) != '0)
			&& (stages[1].data_bank == req.data_bank);
		chk.dir_stall = ((need_chk & RES_DIR_RD) != '0)
			&& ((d_stage.res & RES_DIR_WR) != '0)
			&& (d_stage.dir_bank == req.dir_bank);
		chk.accept = known_src && !stages[0].valid && !chk.set_conflict
			&& !chk.data_stall && !chk.dir_stall;
	end

	// Oldest grant task wins: scanning upwards lets the highest stage overwrite.
	always_comb begin
		grant = '0;
		for (int i = GRANT_LO; i <= GRANT_HI; i++) begin
			if (stages[i].valid && stages[i].source == SRC_GRANT
					&& (stages[i].res & RES_GRANT) != '0) begin
				grant.valid = 1'b1;
				grant.tag = stages[i].tag;
				grant.stage_num = GSTAGE_W'(i);
			end
		end
	end

endmodule

>>> rtl/cpas_stages.sv
// Stage scoreboard registers: insertion at stage 0, grant clearing and advance.
module cpas_stages #(
	parameter int PIPE_DEPTH = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              fire,
	input  logic                              tick,
	input  logic                              insert,
	input  cpas_pkg::grant_t                  grant,
	input  cpas_pkg::stage_t                  new_stage,
	output cpas_pkg::stage_t [PIPE_DEPTH-1:0] stages,
	output logic                              busy_next
);
	import cpas_pkg::*;

	stage_t [PIPE_DEPTH-1:0] stage_q;
	stage_t [PIPE_DEPTH-1:0] stage_d;

	always_comb begin
		stage_d = stage_q;
		if (fire && tick) begin
			stage_d[0] = '0;
			for (int k = 1; k < PIPE_DEPTH; k++) begin
				stage_d[k] = stage_q[k-1];
				if (grant.valid && (k - 1) == int'(grant.stage_num))
					stage_d[k].res = stage_q[k-1].res & ~RES_GRANT;
			end
		end else if (fire && insert) begin
			stage_d[0] = new_stage;
		end
	end

	always_comb begin
		busy_next = 1'b0;
		for (int k = 0; k < PIPE_DEPTH; k++)
			busy_next = busy_next | stage_d[k].valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= '0;
		end else begin
			stage_q <= stage_d;
		end
	end

	assign stages = stage_q;

	a_tick_empties_head: assert property (@(posedge clk) disable iff (!arst_n)
		fire && tick |=> !stage_q[0].valid)
		else $error("stage 0 still holds a task after an advance");

	a_insert_fills_head: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !tick && insert |=> stage_q[0].valid)
		else $error("accepted request did not enter stage 0");

	a_grant_is_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		fire && tick && grant.valid && int'(grant.stage_num) == GRANT_HI
		|=> (stage_q[GRANT_HI+1].res & RES_GRANT) == '0)
		else $error("grant buffer bit survived a sent grant");

endmodule
